// ===== sv/ces_pkg.sv =====
// Shared constants, types and helpers of the cascaded exponential smoother.
package ces_pkg;

  localparam int MAX_STAGES_DEF  = 8;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // Smoothing factors are Q0.16 with one extra bit for the value one.
  localparam int BETA_BITS  = 17;
  localparam int BETA_FRAC  = 16;
  localparam logic [BETA_BITS-1:0] BETA_ONE   = 17'd65536;
  localparam logic [BETA_BITS-1:0] BETA_RESET = 17'd32768;

  localparam int STAGES_BITS = 4;
  localparam logic [STAGES_BITS-1:0] STAGES_RESET = 4'd8;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = BETA_BITS;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_BETA_UP   = 2'd0,
    CFG_BETA_DOWN = 2'd1,
    CFG_ASYM_MODE = 2'd2,
    CFG_STAGES    = 2'd3
  } cfg_index_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic load;    // set accumulator to the load value
    logic fire;    // token arrives: update from neighbor data
    logic enable;  // cell is inside the active cascade
  } ces_cell_ctrl_t;

  // Factors above one act as one.
  function automatic logic [BETA_BITS-1:0] beta_clamp(input logic [BETA_BITS-1:0] b);
    return (b > BETA_ONE) ? BETA_ONE : b;
  endfunction

endpackage

// ===== sv/ces_cell.sv =====
// One smoothing cell: holds one stage accumulator and passes a token to its neighbor.
module ces_cell #(
  parameter int ACC_BITS = ces_pkg::SAMPLE_BITS_DEF + ces_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ces_pkg::ces_cell_ctrl_t        ctrl,
  input  logic signed [ACC_BITS-1:0]     load_value,
  input  logic signed [ACC_BITS-1:0]     din,
  input  logic [ces_pkg::BETA_BITS-1:0]  beta,
  output logic signed [ACC_BITS-1:0]     acc,
  output logic                           token
);

  localparam int PROD_BITS = ACC_BITS + ces_pkg::BETA_BITS + 2;

  logic signed [ACC_BITS-1:0]  acc_r, acc_nxt;
  logic                        token_r, token_nxt;
  logic signed [ACC_BITS:0]    diff;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0]  step;

  // The new value stays between old value and input, so the sum never wraps.
  always_comb begin
    diff = {din[ACC_BITS-1], din} - {acc_r[ACC_BITS-1], acc_r};
    prod = diff * $signed({1'b0, beta});
    step = prod[ces_pkg::BETA_FRAC +: ACC_BITS];
    token_nxt = ctrl.fire & ctrl.enable;
    if (ctrl.load) begin
      acc_nxt = load_value;
    end else if (token_nxt) begin
      acc_nxt = acc_r + step;
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      token_r <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      token_r <= token_nxt;
    end
  end

  assign acc   = acc_r;
  assign token = token_r;

endmodule

// ===== sv/cascaded_exponential_smoother_core.sv =====
// Top level of the cascaded exponential smoother: config registers, sequencer, cell chain.
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  in_operation, in_sample
//  out_     output     out_valid/out_stall out_filtered_value
//  cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// On an add, a token walks the N stages in use, one cell per cycle,
// each cell doing one multiply. A load sets every cell and goes straight to the push.
// One item is in flight at a time; the result waits in an output register,
// and a new item is taken while it stalls there.
// Reset (synchronous, rst_n low) clears all accumulators and restores register defaults.
// cfg_ready is always high.
module cascaded_exponential_smoother_core #(
  parameter int MAX_STAGES  = ces_pkg::MAX_STAGES_DEF,
  parameter int SAMPLE_BITS = ces_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = ces_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_operation,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [SAMPLE_BITS-1:0]         out_filtered_value,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ces_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [ces_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int ACC_BITS = SAMPLE_BITS + FRAC_BITS;
  localparam int IDX_BITS = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam logic [ces_pkg::STAGES_BITS:0] MAX_W = (ces_pkg::STAGES_BITS + 1)'(MAX_STAGES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_PUSH = 3'b100
  } state_t;

  state_t                               state_r, state_nxt;
  logic                                 start_r, start_nxt;
  logic [ces_pkg::BETA_BITS-1:0]        beta_r, beta_nxt;
  logic signed [ACC_BITS-1:0]           scaled_r, scaled_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0]        out_value_r, out_value_nxt;

  logic [ces_pkg::BETA_BITS-1:0]        beta_up_r, beta_down_r;
  logic                                 asym_r;
  logic [ces_pkg::STAGES_BITS-1:0]      stages_r;

  logic                                 in_accept;
  logic                                 out_free;
  logic                                 push;
  logic [IDX_BITS-1:0]                  last_idx;
  logic signed [ACC_BITS-1:0]           scaled_in;
  logic signed [ACC_BITS-1:0]           acc_last;
  logic                                 tok_last;
  logic signed [ACC_BITS-1:0]           acc_w [MAX_STAGES];
  logic [MAX_STAGES-1:0]                tok_w;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_up_r   <= ces_pkg::BETA_RESET;
      beta_down_r <= ces_pkg::BETA_RESET;
      asym_r      <= 1'b0;
      stages_r    <= ces_pkg::STAGES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (ces_pkg::cfg_index_t'(cfg_index))
        ces_pkg::CFG_BETA_UP:   beta_up_r   <= cfg_data[ces_pkg::BETA_BITS-1:0];
        ces_pkg::CFG_BETA_DOWN: beta_down_r <= cfg_data[ces_pkg::BETA_BITS-1:0];
        ces_pkg::CFG_ASYM_MODE: asym_r      <= cfg_data[0];
        ces_pkg::CFG_STAGES:    stages_r    <= cfg_data[ces_pkg::STAGES_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Last active cell: zero acts as one stage, too many acts as all.
  always_comb begin
    if (stages_r == '0) begin
      last_idx = '0;
    end else if ({1'b0, stages_r} > MAX_W) begin
      last_idx = IDX_BITS'(MAX_STAGES - 1);
    end else begin
      last_idx = IDX_BITS'(stages_r - 4'd1);
    end
  end

  assign scaled_in = $signed({in_sample, {FRAC_BITS{1'b0}}});
  assign acc_last  = acc_w[last_idx];
  assign tok_last  = tok_w[last_idx];
  assign in_accept = in_valid & ~in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = ~out_valid_r | ~out_stall;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    start_nxt     = 1'b0;
    beta_nxt      = beta_r;
    scaled_nxt    = scaled_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_value_nxt = out_value_r;
    push          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          scaled_nxt = scaled_in;
          if (in_operation) begin
            state_nxt = ST_PUSH;
          end else begin
            start_nxt = 1'b1;
            // Pick the factor against the last stage before any update.
            if (asym_r && (scaled_in < acc_last)) begin
              beta_nxt = ces_pkg::beta_clamp(beta_down_r);
            end else begin
              beta_nxt = ces_pkg::beta_clamp(beta_up_r);
            end
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (tok_last) begin
          if (out_free) begin
            push      = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (push) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = acc_last[FRAC_BITS +: SAMPLE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beta_r      <= beta_nxt;
    scaled_r    <= scaled_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_value_r;

  // Cell chain: cell 0 reads the sample, each later cell reads its left neighbor.
  for (genvar i = 0; i < MAX_STAGES; i++) begin : g_cell
    ces_pkg::ces_cell_ctrl_t    ctrl;
    logic signed [ACC_BITS-1:0] din;

    if (i == 0) begin : g_head
      assign ctrl.fire = start_r;
      assign din       = scaled_r;
    end else begin : g_link
      assign ctrl.fire = tok_w[i-1];
      assign din       = acc_w[i-1];
    end
    assign ctrl.load   = in_accept & in_operation;
    assign ctrl.enable = (IDX_BITS'(i) <= last_idx);

    ces_cell #(
      .ACC_BITS (ACC_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .load_value (scaled_in),
      .din        (din),
      .beta       (beta_r),
      .acc        (acc_w[i]),
      .token      (tok_w[i])
    );
  end

  // Assertions.
  a_token_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (start_r || (|tok_w)) |-> (state_r == ST_RUN))
    else $error("token in cell chain outside run state");

  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({tok_w, start_r}))
    else $error("more than one token in cell chain");

  a_load_to_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_operation) |=> (state_r == ST_PUSH))
    else $error("load transfer did not go straight to result push");

  a_push_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("pending result not moved into free output register");

endmodule
